FILE: rtl/mcfir_pkg.sv
// Shared constants and types for the multichannel FIR filter.
package mcfir_pkg;

   localparam int TAPS_DEF     = 8;
   localparam int CHANNELS_DEF = 2;
   localparam int NUM_COEF     = 8;
   localparam int COEF_IDX_W   = 3;
   localparam int SAMPLE_W     = 16;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int PAIR_W       = PROD_W + 1;
   localparam int ACC_W        = 36;
   localparam int CH_IDX_W     = 3;
   localparam int FRAC_SHIFT   = 14;
   localparam int ROUND_BIAS   = 8192;
   localparam int OUT_MAX      = 32767;
   localparam int OUT_MIN      = -32768;
   localparam logic signed [SAMPLE_W-1:0] COEF_ONE = 16'sd16384;

   // Per-cycle control seen by every tap cell.
   typedef struct packed {
      logic                shift;
      logic [CH_IDX_W-1:0] chan;
   } cell_ctrl_type;

   // Tag that travels with a request down the summing pipeline.
   typedef struct packed {
      logic valid;
      logic chan;
   } stage_tag_type;

endpackage

FILE: rtl/mcfir_tap_cell.sv
// One tap cell: per-channel delay entry when STORE is set, coefficient multiply, handoff to neighbor.
module mcfir_tap_cell #(
   parameter int CHANNELS = mcfir_pkg::CHANNELS_DEF,
   parameter bit STORE    = 1'b1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mcfir_pkg::cell_ctrl_type               ctrl,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]  coef,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]  data_in,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0]  data_out,
   output logic signed [mcfir_pkg::PROD_W-1:0]    prod_ff
);
   import mcfir_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic signed [SAMPLE_W-1:0] entry;
   logic signed [PROD_W-1:0]   prod_in;

   if (STORE) begin : g_store
      logic signed [SAMPLE_W-1:0] entry_ff [CHANNELS];

      assign entry = entry_ff[ctrl.chan[CH_W-1:0]];

      // shift: take the neighbor's entry for this channel
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int c = 0; c < CHANNELS; c++) begin
               entry_ff[c] <= '0;
            end
         end else if (ctrl.shift) begin
            entry_ff[ctrl.chan[CH_W-1:0]] <= data_in;
         end
      end
   end else begin : g_newest
      assign entry = data_in;
   end

   assign data_out = entry;
   assign prod_in  = coef * entry;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: rtl/mcfir_acc.sv
// Summing pipeline: pair adds, final add, round and saturate into the output register.
module mcfir_acc #(
   parameter int TAPS = mcfir_pkg::TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mcfir_pkg::stage_tag_type              tag,
   input  logic signed [mcfir_pkg::PROD_W-1:0]   prod [TAPS],
   output logic                                  take,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                  rsp_channel_out,
   output logic                                  rsp_saturated
);
   import mcfir_pkg::*;

   localparam int NPAIR = (TAPS + 1) / 2;
   localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(OUT_MIN);
   localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'(ROUND_BIAS);

   stage_tag_type             tag2_ff, tag3_ff;
   logic signed [PAIR_W-1:0]  pair_in [NPAIR];
   logic signed [PAIR_W-1:0]  pair_ff [NPAIR];
   logic signed [ACC_W-1:0]   acc_in, acc_ff;
   logic signed [ACC_W-1:0]   rounded, scaled;
   logic                      en2, en3, en_out;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                      sat_in;

   // advance a stage when it is empty or the next one advances
   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en3    = !tag3_ff.valid || en_out;
   assign en2    = !tag2_ff.valid || en3;
   assign take   = en2;

   for (genvar j = 0; j < NPAIR; j++) begin : g_pair
      if (2 * j + 1 < TAPS) begin : g_two
         assign pair_in[j] = PAIR_W'(prod[2*j]) + PAIR_W'(prod[2*j+1]);
      end else begin : g_one
         assign pair_in[j] = PAIR_W'(prod[2*j]);
      end
   end

   always_comb begin
      acc_in = '0;
      for (int j = 0; j < NPAIR; j++) begin
         acc_in = acc_in + ACC_W'(pair_ff[j]);
      end
   end

   // round half up, drop the fraction, clamp to 16 bits
   assign rounded = acc_ff + BIAS;
   assign scaled  = rounded >>> FRAC_SHIFT;

   always_comb begin
      sat_in = 1'b0;
      sample_in = scaled[SAMPLE_W-1:0];
      if (scaled > MAX_V) begin
         sat_in    = 1'b1;
         sample_in = MAX_V[SAMPLE_W-1:0];
      end else if (scaled < MIN_V) begin
         sat_in    = 1'b1;
         sample_in = MIN_V[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en2) begin
            tag2_ff <= tag;
         end
         if (en3) begin
            tag3_ff <= tag2_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= tag3_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && tag.valid) begin
         pair_ff <= pair_in;
      end
      if (en3 && tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (en_out && tag3_ff.valid) begin
         rsp_sample_out  <= sample_in;
         rsp_channel_out <= tag3_ff.chan;
         rsp_saturated   <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/multichannel_fir_filter.sv
// Multichannel FIR filter: one 16-bit request per cycle while req_stall is low; a
// response passes the product register, the pair-add register, the final-add register
// and the output register. Every tap cell but the newest keeps one delay entry per
// channel, multiplies it by its coefficient on accept and hands the entry to its older
// neighbor, so a request on any channel may follow any other in the next cycle. Samples
// are Q1.15, coefficients Q2.14; the sum is rounded half up and saturated, with
// rsp_saturated set when it clamps. Coefficients reset to zero except the last, which
// resets to 1.0, so the filter passes samples through at reset with TAPS at eight. Write
// coefficients through the csr port only while no request is in flight; csr_ready is
// always high.
module multichannel_fir_filter #(
   parameter int TAPS     = mcfir_pkg::TAPS_DEF,
   parameter int CHANNELS = mcfir_pkg::CHANNELS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic                                    req_channel_in,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                    rsp_channel_out,
   output logic                                    rsp_saturated,
   // coefficient write port
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mcfir_pkg::COEF_IDX_W-1:0]        csr_index,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]   csr_data
);
   import mcfir_pkg::*;

   logic signed [SAMPLE_W-1:0] coef_ff [NUM_COEF];
   logic signed [SAMPLE_W-1:0] chain   [TAPS];
   logic signed [PROD_W-1:0]   prod    [TAPS];
   cell_ctrl_type              ctrl;
   stage_tag_type              tag1_ff;
   logic                       take;
   logic                       en1;
   logic                       accept;

   // Coefficient registers: always ready, reset to the pass-through filter when TAPS is eight.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= (i == NUM_COEF - 1) ? COEF_ONE : '0;
         end
      end else if (csr_valid && csr_ready) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // Product stage advances when empty or when the summing pipeline takes it.
   assign en1       = !tag1_ff.valid || take;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   // Shift the delay line of the selected channel on every accepted request.
   // A single channel folds every request onto delay line zero.
   always_comb begin
      ctrl.shift = accept;
      ctrl.chan  = (CHANNELS > 1) ? CH_IDX_W'(req_channel_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (en1) begin
         tag1_ff.valid <= accept;
         tag1_ff.chan  <= req_channel_in;
      end
   end

   // Cell TAPS-1 takes the new sample directly; older cells each hold one delay entry
   // per channel and load it from the next younger cell.
   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == TAPS - 1) begin : g_newest
         mcfir_tap_cell #(
            .CHANNELS (CHANNELS),
            .STORE    (1'b0)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .coef     (coef_ff[i]),
            .data_in  (req_sample_in),
            .data_out (chain[i]),
            .prod_ff  (prod[i])
         );
      end else begin : g_delay
         mcfir_tap_cell #(
            .CHANNELS (CHANNELS),
            .STORE    (1'b1)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .coef     (coef_ff[i]),
            .data_in  (chain[i+1]),
            .data_out (chain[i]),
            .prod_ff  (prod[i])
         );
      end
   end

   // Add the products, round, saturate and hold the response until taken.
   mcfir_acc #(
      .TAPS (TAPS)
   ) u_acc (
      .clock           (clock),
      .reset           (reset),
      .tag             (tag1_ff),
      .prod            (prod),
      .take            (take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_channel_out (rsp_channel_out),
      .rsp_saturated   (rsp_saturated)
   );

   // The input stalls only behind a response that is waiting.
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A response that drains frees the whole pipeline for a new request.
   a_drain_frees_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side drains");

   // An accepted request occupies the product stage in the next cycle.
   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> tag1_ff.valid)
      else $error("accepted request lost at product stage");

endmodule
